### rtl/tms_pkg.sv
// Shared types and constants for the Turing machine stepper.
package tms_pkg;

    localparam int TAPE_DEPTH_DEF = 256;
    localparam int RULE_DEPTH_DEF = 512;

    localparam int SYM_W   = 8;
    localparam int STATE_W = 8;
    localparam int IDX_W   = 9;
    localparam int RCNT_W  = 10;
    localparam int CFG_W   = 10;
    localparam int CFGA_W  = 3;
    localparam int HIT_W   = 9;

    // item kinds carried in the input tuser
    localparam logic [2:0] ACT_WRITE_RULE = 3'd0;
    localparam logic [2:0] ACT_SET_FINAL  = 3'd1;
    localparam logic [2:0] ACT_START      = 3'd2;
    localparam logic [2:0] ACT_WRITE_CELL = 3'd3;
    localparam logic [2:0] ACT_STEP       = 3'd4;
    localparam logic [2:0] ACT_READ_CELL  = 3'd5;

    // configuration register indexes
    localparam logic [CFGA_W-1:0] CFG_INITIAL_STATE = 3'd0;
    localparam logic [CFGA_W-1:0] CFG_BLANK_SYMBOL  = 3'd1;
    localparam logic [CFGA_W-1:0] CFG_LOAD_POSITION = 3'd2;
    localparam logic [CFGA_W-1:0] CFG_TAPE_SIZE     = 3'd3;
    localparam logic [CFGA_W-1:0] CFG_RULE_COUNT    = 3'd4;

    typedef struct packed {
        logic               move_right;
        logic [SYM_W-1:0]   write_symbol;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   read_symbol;
        logic [STATE_W-1:0] from_state;
    } rule_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

### rtl/tms_rule_scan.sv
// Rule table memory and the in-order first-match scan over it.
module tms_rule_scan
    import tms_pkg::*;
#(
    parameter int RULE_DEPTH = RULE_DEPTH_DEF,
    parameter int RULE_AW    = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [RULE_AW-1:0] wr_addr,
    input  rule_t              wr_rule,
    input  logic               start,
    input  logic [RCNT_W-1:0]  rule_count,
    input  logic [STATE_W-1:0] key_state,
    input  logic [SYM_W-1:0]   key_symbol,
    output scan_status_t       status,
    output logic [RULE_AW-1:0] hit_slot,
    output rule_t              hit_rule
);

    localparam int RULE_CW = $clog2(RULE_DEPTH + 1);

    rule_t               rule_mem [RULE_DEPTH];
    rule_t               rule_q;
    logic [RULE_CW-1:0]  cnt_reg, cnt_next;
    logic [RULE_AW-1:0]  slot_reg, slot_next;
    logic                pend_reg, pend_next;
    logic                busy_reg, busy_next;
    logic                match;
    logic                more;

    always_comb
    begin
        match = pend_reg && (rule_q.from_state == key_state)
                && (rule_q.read_symbol == key_symbol);
        more  = busy_reg && !match && (32'(cnt_reg) < 32'(rule_count))
                && (32'(cnt_reg) < RULE_DEPTH);
        status.done  = busy_reg && !more;
        status.found = match;

        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        pend_next = pend_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            pend_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!more)
            begin
                busy_next = 1'b0;
                pend_next = 1'b0;
            end
            else
            begin
                // issue the next slot; its compare lands in the following cycle
                cnt_next  = cnt_reg + RULE_CW'(1);
                slot_next = cnt_reg[RULE_AW-1:0];
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            slot_reg <= '0;
            pend_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            slot_reg <= slot_next;
            pend_reg <= pend_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem[wr_addr] <= wr_rule;
        end
        if (more)
        begin
            rule_q <= rule_mem[cnt_reg[RULE_AW-1:0]];
        end
    end

    assign hit_slot = slot_reg;
    assign hit_rule = rule_q;

endmodule

### rtl/turing_machine_stepper_core.sv
// Top level of the single-tape Turing machine stepper.
//
// Usage: requests enter on the s_ channel (tvalid/tready, kind in tuser,
// operands in tdata); every request produces exactly one result on the m_
// channel with the machine state, head, cell data, taken rule and status.
// Registers are written through the cfg_ channel, which is always ready;
// write it only while no request is in flight.
// Work per request, from accept to result valid:
//   rule write, final mark, cell write/read, odd kinds, step while halted:
//         straight to the response phase.
//   step: slots are scanned in order up to the first match or the last of n
//         slots; the rule memory hands out one slot per cycle.
//   start: all TAPE_DEPTH (capped at 256) cells of the tape memory are filled
//         with the blank symbol one cell per cycle through its write port.
// One request is worked at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is still stalled.
// If the receiver stalls, the finished result waits in the engine until the
// output register frees up, and no new request is taken meanwhile.
// Reset: halted, not faulted, state 0, head 0, final marks cleared, registers
// at their reset values. Rule and tape contents are undefined until written.
module turing_machine_stepper_core
    import tms_pkg::*;
#(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
    parameter int RULE_DEPTH = RULE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    // tuser: action[2:0]
    input  logic [2:0]        s_tuser,
    // tdata: index[8:0], from_state[16:9], read_symbol[24:17], to_state[32:25],
    //        write_symbol[40:33], move_right[41], is_final[42], zero[47:43]
    input  logic [47:0]       s_tdata,
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    // tdata: machine_state[7:0], head_position[15:8], cell_symbol[23:16],
    //        rule_hit[32:24], stepped[33], halted[34], accepted[35], fault[36],
    //        zero[39:37]
    output logic [39:0]       m_tdata,
    // register write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGA_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int TAPE_USE = (TAPE_DEPTH < 256) ? TAPE_DEPTH : 256;
    localparam int TAPE_AW  = $clog2(TAPE_USE);
    localparam int RULE_AW  = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FILL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_RESP = 4'b1000
    } fsm_t;

    // request fields
    logic [2:0]         in_action;
    logic [IDX_W-1:0]   in_index;
    rule_t              in_rule;
    logic               in_final;

    assign in_action            = s_tuser;
    assign in_index             = s_tdata[8:0];
    assign in_rule.from_state   = s_tdata[16:9];
    assign in_rule.read_symbol  = s_tdata[24:17];
    assign in_rule.to_state     = s_tdata[32:25];
    assign in_rule.write_symbol = s_tdata[40:33];
    assign in_rule.move_right   = s_tdata[41];
    assign in_final             = s_tdata[42];

    // configuration
    logic [STATE_W-1:0] init_state_reg;
    logic [SYM_W-1:0]   blank_reg;
    logic [7:0]         load_pos_reg;
    logic [8:0]         tape_size_reg;
    logic [RCNT_W-1:0]  rule_count_reg;

    // machine state
    fsm_t               fsm_reg, fsm_next;
    logic [STATE_W-1:0] state_reg, state_next;
    logic [7:0]         head_reg, head_next;
    logic               halt_reg, halt_next;
    logic               fault_reg, fault_next;
    logic [255:0]       final_reg;
    logic [TAPE_AW-1:0] fill_cnt_reg, fill_cnt_next;
    logic               under_ok_reg, under_ok_next;

    // per-request result holding
    logic [SYM_W-1:0]   cell_reg, cell_next;
    logic [HIT_W-1:0]   hit_reg, hit_next;
    logic               stepped_reg, stepped_next;
    logic               cell_mem_reg, cell_mem_next;

    // output register
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    // tape memory
    logic [SYM_W-1:0]   tape_mem [TAPE_USE];
    logic [SYM_W-1:0]   tape_q;
    logic               tape_we;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [SYM_W-1:0]   tape_wdata;
    logic               tape_re;
    logic [TAPE_AW-1:0] tape_raddr;

    // rule scan
    logic               rule_we;
    logic [RULE_AW-1:0] rule_waddr;
    logic               scan_start;
    scan_status_t       scan_st;
    logic [RULE_AW-1:0] hit_slot;
    rule_t              hit_rule;
    logic [SYM_W-1:0]   under_sym;

    logic               in_fire;
    logic               out_free;
    logic [8:0]         size_c;
    logic               idx_ok;
    logic [RULE_AW+IDX_W-1:0] idx_wide;
    logic [RULE_AW+HIT_W-1:0] slot_wide;
    logic               accepted;
    logic [SYM_W-1:0]   cell_out;

    assign s_tready  = (fsm_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // usable tape length: never past the memory or the 8-bit head
    assign size_c    = (tape_size_reg > 9'(TAPE_USE)) ? 9'(TAPE_USE) : tape_size_reg;
    assign idx_ok    = in_index < size_c;
    assign idx_wide  = (RULE_AW + IDX_W)'(in_index);
    assign slot_wide = (RULE_AW + HIT_W)'(hit_slot);
    assign under_sym = under_ok_reg ? tape_q : '0;

    assign rule_we    = in_fire && (in_action == ACT_WRITE_RULE)
                        && (32'(in_index) < RULE_DEPTH);
    assign rule_waddr = idx_wide[RULE_AW-1:0];
    assign scan_start = in_fire && (in_action == ACT_STEP) && !halt_reg;

    tms_rule_scan #(
        .RULE_DEPTH (RULE_DEPTH),
        .RULE_AW    (RULE_AW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (rule_we),
        .wr_addr    (rule_waddr),
        .wr_rule    (in_rule),
        .start      (scan_start),
        .rule_count (rule_count_reg),
        .key_state  (state_reg),
        .key_symbol (under_sym),
        .status     (scan_st),
        .hit_slot   (hit_slot),
        .hit_rule   (hit_rule)
    );

    // main sequencer
    always_comb
    begin
        fsm_next      = fsm_reg;
        state_next    = state_reg;
        head_next     = head_reg;
        halt_next     = halt_reg;
        fault_next    = fault_reg;
        fill_cnt_next = fill_cnt_reg;
        under_ok_next = under_ok_reg;
        cell_next     = cell_reg;
        hit_next      = hit_reg;
        stepped_next  = stepped_reg;
        cell_mem_next = cell_mem_reg;
        tape_we       = 1'b0;
        tape_waddr    = in_index[TAPE_AW-1:0];
        tape_wdata    = in_rule.write_symbol;
        tape_re       = 1'b0;
        tape_raddr    = in_index[TAPE_AW-1:0];

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cell_next     = '0;
                    hit_next      = '0;
                    stepped_next  = 1'b0;
                    cell_mem_next = 1'b0;
                    fsm_next      = ST_RESP;
                    unique case (in_action)
                        ACT_START:
                        begin
                            state_next    = init_state_reg;
                            head_next     = load_pos_reg;
                            halt_next     = 1'b0;
                            fault_next    = 1'b0;
                            if ({1'b0, load_pos_reg} >= size_c)
                            begin
                                halt_next  = 1'b1;
                                fault_next = 1'b1;
                            end
                            fill_cnt_next = '0;
                            fsm_next      = ST_FILL;
                        end
                        ACT_WRITE_CELL:
                        begin
                            if (idx_ok)
                            begin
                                tape_we = 1'b1;
                            end
                            else
                            begin
                                halt_next  = 1'b1;
                                fault_next = 1'b1;
                            end
                        end
                        ACT_READ_CELL:
                        begin
                            if (idx_ok)
                            begin
                                tape_re       = 1'b1;
                                cell_mem_next = 1'b1;
                            end
                            else
                            begin
                                halt_next  = 1'b1;
                                fault_next = 1'b1;
                            end
                        end
                        ACT_STEP:
                        begin
                            if (!halt_reg)
                            begin
                                // fetch the cell under the head while the scan spins up
                                under_ok_next = {1'b0, head_reg} < size_c;
                                tape_re       = 1'b1;
                                tape_raddr    = head_reg[TAPE_AW-1:0];
                                fsm_next      = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // rule and final-mark writes act outside this block;
                            // unused kinds only report status
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                tape_we       = 1'b1;
                tape_waddr    = fill_cnt_reg;
                tape_wdata    = blank_reg;
                fill_cnt_next = fill_cnt_reg + TAPE_AW'(1);
                if (fill_cnt_reg == TAPE_AW'(TAPE_USE - 1))
                begin
                    fsm_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (scan_st.done)
                begin
                    fsm_next = ST_RESP;
                    if (!scan_st.found)
                    begin
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        tape_we      = under_ok_reg;
                        tape_waddr   = head_reg[TAPE_AW-1:0];
                        tape_wdata   = hit_rule.write_symbol;
                        state_next   = hit_rule.to_state;
                        cell_next    = hit_rule.write_symbol;
                        hit_next     = slot_wide[HIT_W-1:0];
                        stepped_next = 1'b1;
                        if (hit_rule.move_right)
                        begin
                            if (({1'b0, head_reg} + 9'd1) >= size_c)
                            begin
                                halt_next  = 1'b1;
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            if (head_reg == 8'd0)
                            begin
                                halt_next  = 1'b1;
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg - 8'd1;
                            end
                        end
                    end
                end
            end
            ST_RESP:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    fsm_next = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    assign accepted = halt_reg && !fault_reg && final_reg[state_reg];
    assign cell_out = cell_mem_reg ? tape_q : cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= ST_IDLE;
            state_reg      <= '0;
            head_reg       <= '0;
            halt_reg       <= 1'b1;
            fault_reg      <= 1'b0;
            final_reg      <= '0;
            fill_cnt_reg   <= '0;
            under_ok_reg   <= 1'b0;
            cell_reg       <= '0;
            hit_reg        <= '0;
            stepped_reg    <= 1'b0;
            cell_mem_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            init_state_reg <= '0;
            blank_reg      <= '0;
            load_pos_reg   <= '0;
            tape_size_reg  <= 9'd256;
            rule_count_reg <= '0;
        end
        else
        begin
            fsm_reg      <= fsm_next;
            state_reg    <= state_next;
            head_reg     <= head_next;
            halt_reg     <= halt_next;
            fault_reg    <= fault_next;
            fill_cnt_reg <= fill_cnt_next;
            under_ok_reg <= under_ok_next;
            cell_reg     <= cell_next;
            hit_reg      <= hit_next;
            stepped_reg  <= stepped_next;
            cell_mem_reg <= cell_mem_next;

            if (in_fire && (in_action == ACT_SET_FINAL))
            begin
                final_reg[in_rule.from_state] <= in_final;
            end

            // output register: load on the way out of RESP, drop on handshake
            if ((fsm_reg == ST_RESP) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_STATE: init_state_reg <= cfg_data[STATE_W-1:0];
                    CFG_BLANK_SYMBOL:  blank_reg      <= cfg_data[SYM_W-1:0];
                    CFG_LOAD_POSITION: load_pos_reg   <= cfg_data[7:0];
                    CFG_TAPE_SIZE:     tape_size_reg  <= cfg_data[8:0];
                    CFG_RULE_COUNT:    rule_count_reg <= cfg_data[RCNT_W-1:0];
                    default:
                    begin
                        // writes past the register list are dropped
                    end
                endcase
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if ((fsm_reg == ST_RESP) && out_free)
        begin
            m_tdata_reg <= {3'b000, fault_reg, accepted, halt_reg, stepped_reg,
                            hit_reg, cell_out, head_reg, state_reg};
        end
    end

    // tape memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_re)
        begin
            tape_q <= tape_mem[tape_raddr];
        end
    end

    // a scan can only finish while the sequencer waits for it
    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_st.done |-> (fsm_reg == ST_SCAN))
        else $error("rule scan finished outside the scan phase");

    // a fault always comes with a halt
    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> halt_reg)
        else $error("fault flag set while machine runs");

    // a result appears only out of the response phase
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(fsm_reg) == ST_RESP))
        else $error("result loaded outside the response phase");

    // no request is taken while a scan is running
    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_SCAN) |-> !s_tready)
        else $error("request accepted during a rule scan");

endmodule
